// ===== sv/pfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    localparam int PAGE_W             = 13;
    localparam int COUNT_W            = 16;
    localparam int NUM_PAGES_DEF      = 8192;
    localparam int RESERVED_PAGES_DEF = 1024;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_INCREF = 2'd1,
        FUNC_DECREF = 2'd2,
        FUNC_FREE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        func_t              func;
        logic [PAGE_W-1:0]  page_index;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [PAGE_W-1:0]  page_out;
        logic [COUNT_W-1:0] ref_after;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_LOOK  = 2'd2,
        ST_ALLOC = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic lookup_alloc;
        logic commit_op;
        logic commit_alloc;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic alloc_req;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/page_frame_allocator_refcount_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_t : func, page_index
// rsp       out        rsp_valid / rsp_ready  rsp_t : status, page_out, ref_after
//
// Increment, decrement and free: the registered read of the count memory, then the
// commit into the output register. Allocate: the stack read, then the count read at
// the allocated page, then the commit. One request in flight; the next is taken once
// its result sits in the output register, even while that result waits.
// After reset a clearing pass writes every count, with req_ready low.
// A stalled rsp holds the output register and delays the commit of the next request.

module page_frame_allocator_refcount_unit
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES      = NUM_PAGES_DEF,
    parameter int RESERVED_PAGES = RESERVED_PAGES_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    pfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pfa_datapath #(
        .NUM_PAGES      (NUM_PAGES),
        .RESERVED_PAGES (RESERVED_PAGES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== sv/pfa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfa_ctrl
    import pfa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (stat.alloc_req)
                begin
                    state_next = ST_ALLOC;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ALLOC:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            ST_LOOK:
            begin
                cmd.lookup_alloc = stat.alloc_req;
                cmd.commit_op    = !stat.alloc_req && stat.out_free;
            end
            ST_ALLOC:
            begin
                cmd.commit_alloc = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pfa_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfa_datapath
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES      = NUM_PAGES_DEF,
    parameter int RESERVED_PAGES = RESERVED_PAGES_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ctrl_cmd_t cmd,
    output dp_stat_t       stat,
    input  wire req_t      req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_t           rsp
);

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int TW  = $clog2(NUM_PAGES + 1);
    localparam int XW  = (TW > PAGE_W) ? TW : PAGE_W;
    localparam int RSV = (RESERVED_PAGES > NUM_PAGES) ? NUM_PAGES : RESERVED_PAGES;

    logic [COUNT_W-1:0] cnt_mem [NUM_PAGES];
    logic [PAGE_W-1:0]  stk_mem [NUM_PAGES];

    logic [COUNT_W-1:0] cnt_rd_reg;
    logic [PAGE_W-1:0]  stk_rd_reg;

    func_t              func_reg;
    logic [PAGE_W-1:0]  pg_reg;
    logic [PW-1:0]      alloc_page_reg;
    logic [PW-1:0]      alloc_page_next;
    logic               alloc_ok_reg;
    logic               alloc_ok_next;

    logic [TW-1:0]      stack_top_reg;
    logic [TW-1:0]      stack_top_next;
    logic [TW-1:0]      next_fresh_reg;
    logic [TW-1:0]      next_fresh_next;
    logic [TW-1:0]      clr_idx_reg;
    logic [TW-1:0]      clr_idx_next;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic               cnt_re;
    logic [PW-1:0]      cnt_raddr;
    logic               cnt_we;
    logic [PW-1:0]      cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;

    logic               stk_we;
    logic [PW-1:0]      stk_raddr;

    logic               in_range;
    logic               stack_full;
    status_t            op_status;
    logic [COUNT_W-1:0] op_after;
    logic               op_we;
    logic [COUNT_W-1:0] op_wdata;
    logic               op_push;

    assign in_range   = XW'(pg_reg) < XW'(NUM_PAGES);
    assign stack_full = stack_top_reg >= TW'(NUM_PAGES);

    always_comb
    begin
        op_status = STATUS_OK;
        op_after  = cnt_rd_reg;
        op_we     = 1'b0;
        op_wdata  = cnt_rd_reg;
        op_push   = 1'b0;
        case (func_reg)
            FUNC_INCREF:
            begin
                if (cnt_rd_reg == COUNT_MAX)
                begin
                    op_status = STATUS_RANGE;
                end
                else
                begin
                    op_we    = 1'b1;
                    op_wdata = cnt_rd_reg + COUNT_W'(1);
                    op_after = cnt_rd_reg + COUNT_W'(1);
                end
            end
            FUNC_DECREF:
            begin
                if (cnt_rd_reg == '0)
                begin
                    op_status = STATUS_RANGE;
                end
                else
                begin
                    op_we    = 1'b1;
                    op_wdata = cnt_rd_reg - COUNT_W'(1);
                    op_after = cnt_rd_reg - COUNT_W'(1);
                    op_push  = cnt_rd_reg == COUNT_W'(1);
                end
            end
            FUNC_FREE:
            begin
                op_push = 1'b1;
            end
            default:
            begin
                op_status = STATUS_OK;
            end
        endcase
        if (!in_range)
        begin
            op_status = STATUS_RANGE;
            op_after  = '0;
            op_we     = 1'b0;
            op_push   = 1'b0;
        end
    end

    always_comb
    begin
        alloc_page_next = PW'(next_fresh_reg);
        alloc_ok_next   = 1'b0;
        stack_top_next  = stack_top_reg;
        next_fresh_next = next_fresh_reg;
        stk_we          = 1'b0;
        if (cmd.lookup_alloc)
        begin
            if (stack_top_reg != '0)
            begin
                alloc_page_next = PW'(stk_rd_reg);
                alloc_ok_next   = 1'b1;
                stack_top_next  = stack_top_reg - TW'(1);
            end
            else if (next_fresh_reg < TW'(NUM_PAGES))
            begin
                alloc_ok_next   = 1'b1;
                next_fresh_next = next_fresh_reg + TW'(1);
            end
        end
        if (cmd.commit_op && op_push && !stack_full)
        begin
            stk_we         = 1'b1;
            stack_top_next = stack_top_reg + TW'(1);
        end
    end

    assign stk_raddr    = PW'(stack_top_reg - TW'(1));
    assign clr_idx_next = cmd.clear_step ? clr_idx_reg + TW'(1) : clr_idx_reg;

    always_comb
    begin
        cnt_re    = cmd.accept || cmd.lookup_alloc;
        cnt_raddr = cmd.accept ? PW'(req.page_index) : alloc_page_next;
        cnt_we    = 1'b0;
        cnt_waddr = PW'(pg_reg);
        cnt_wdata = op_wdata;
        if (cmd.clear_step)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = PW'(clr_idx_reg);
            cnt_wdata = (clr_idx_reg < TW'(RSV)) ? COUNT_W'(1) : '0;
        end
        else if (cmd.commit_op && op_we)
        begin
            cnt_we = 1'b1;
        end
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (cmd.commit_op)
        begin
            rsp_next.status    = op_status;
            rsp_next.page_out  = pg_reg;
            rsp_next.ref_after = op_after;
            rsp_valid_next     = 1'b1;
        end
        else if (cmd.commit_alloc)
        begin
            if (alloc_ok_reg)
            begin
                rsp_next.status    = STATUS_OK;
                rsp_next.page_out  = PAGE_W'(alloc_page_reg);
                rsp_next.ref_after = cnt_rd_reg;
            end
            else
            begin
                rsp_next.status    = STATUS_EMPTY;
                rsp_next.page_out  = '0;
                rsp_next.ref_after = '0;
            end
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[PW'(stack_top_reg)] <= pg_reg;
        end
        if (cmd.accept)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= req.func;
            pg_reg   <= req.page_index;
        end
        if (cmd.lookup_alloc)
        begin
            alloc_page_reg <= alloc_page_next;
            alloc_ok_reg   <= alloc_ok_next;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_top_reg  <= '0;
            next_fresh_reg <= TW'(RSV);
            clr_idx_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            stack_top_reg  <= stack_top_next;
            next_fresh_reg <= next_fresh_next;
            clr_idx_reg    <= clr_idx_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    assign stat.clear_last = clr_idx_reg == TW'(NUM_PAGES - 1);
    assign stat.alloc_req  = func_reg == FUNC_ALLOC;
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_top_reg <= TW'(NUM_PAGES))
        else $error("free stack pointer beyond depth");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (next_fresh_reg <= TW'(NUM_PAGES)) && (next_fresh_reg >= TW'(RSV)))
        else $error("fresh page counter out of bounds");

    a_one_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear_step, cmd.accept, cmd.lookup_alloc, cmd.commit_op,
                  cmd.commit_alloc}))
        else $error("conflicting datapath commands");

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit_op || cmd.commit_alloc) |-> (!rsp_valid_reg || rsp_ready))
        else $error("result overwritten before transfer");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.commit_op || cmd.commit_alloc))
        else $error("result raised without commit");

endmodule

`default_nettype wire
